/* hw/rtl/cda_pkg.sv */
`default_nettype none

package cda_pkg;

	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int CNT_W  = 22;
	localparam int ACC_W  = 24;

	localparam int YEAR_FIELD_MAX = 16383;

	localparam logic [ACC_W-1:0] DAYS_400Y = ACC_W'(146097);
	localparam logic [ACC_W-1:0] DAYS_100Y = ACC_W'(36524);
	localparam logic [ACC_W-1:0] DAYS_4Y   = ACC_W'(1461);
	localparam logic [ACC_W-1:0] DAYS_1Y   = ACC_W'(365);
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic KIND_DIFF = 1'b0;
	localparam logic KIND_ADD  = 1'b1;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_BEFORE = 2'd1;
	localparam logic [1:0] STAT_OVF    = 2'd2;

	typedef struct packed {
		logic             sub;
		logic [ACC_W-1:0] a;
		logic [ACC_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ACC_W-1:0] res;
		logic             borrow;
	} alu_rsp_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] n;
		case (m)
			4'd2: n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

	function automatic logic [8:0] cum_days(input logic [MON_W-1:0] m);
		logic [8:0] n;
		case (m)
			4'd2: n = 9'd31;
			4'd3: n = 9'd59;
			4'd4: n = 9'd90;
			4'd5: n = 9'd120;
			4'd6: n = 9'd151;
			4'd7: n = 9'd181;
			4'd8: n = 9'd212;
			4'd9: n = 9'd243;
			4'd10: n = 9'd273;
			4'd11: n = 9'd304;
			4'd12: n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/cda_alu.sv */
`default_nettype none

module cda_alu (
	input  wire cda_pkg::alu_req_t req,
	output cda_pkg::alu_rsp_t      rsp
);

	logic [cda_pkg::ACC_W:0] full;

	assign full = req.sub ? ({1'b0, req.a} - {1'b0, req.b}) : ({1'b0, req.a} + {1'b0, req.b});

	assign rsp.res    = full[cda_pkg::ACC_W-1:0];
	assign rsp.borrow = full[cda_pkg::ACC_W];

endmodule

`default_nettype wire

/* hw/rtl/cda_clamp.sv */
`default_nettype none

module cda_clamp #(
	parameter int TOP_YEAR = 9999
) (
	input  wire logic [cda_pkg::DAY_W-1:0]  day,
	input  wire logic [cda_pkg::MON_W-1:0]  month,
	input  wire logic [cda_pkg::YEAR_W-1:0] year,
	output logic      [cda_pkg::DAY_W-1:0]  day_c,
	output logic      [cda_pkg::MON_W-1:0]  month_c,
	output logic      [cda_pkg::YEAR_W-1:0] year_m1
);

	localparam logic [cda_pkg::YEAR_W-1:0] TOP = cda_pkg::YEAR_W'(TOP_YEAR);

	logic [cda_pkg::YEAR_W-1:0] year_c;

	always_comb begin
		if (year == '0) begin
			year_c = cda_pkg::YEAR_W'(1);
		end else if (year > TOP) begin
			year_c = TOP;
		end else begin
			year_c = year;
		end
		if (month == '0) begin
			month_c = cda_pkg::MON_W'(1);
		end else if (month > cda_pkg::MON_W'(12)) begin
			month_c = cda_pkg::MON_W'(12);
		end else begin
			month_c = month;
		end
		day_c   = (day == '0) ? cda_pkg::DAY_W'(1) : day;
		year_m1 = year_c - cda_pkg::YEAR_W'(1);
	end

endmodule

`default_nettype wire

/* hw/rtl/calendar_date_arithmetic.sv */
// Gregorian date arithmetic unit.
// Command channel: drive kind, both dates and day_count with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
// busy stays high from the cycle after that edge until the result goes out.
// Result channel: done is high for exactly one cycle with days_between,
// result_day, result_month, result_year and status; the receiver cannot stall
// and must take it in that cycle. busy falls in the same cycle, so the next
// command may be taken at the edge that ends it.
// Each date is reduced to a day number by stepping one shared adder over the
// 400-, 100-, 4- and 1-year blocks of (year - 1), one block per cycle, then
// adding month and day. Kind 0 subtracts date b from date a; kind 1 adds the
// count to date a, checks it against the top year, and splits the sum back
// through the same blocks and then one month per cycle.
// Reset returns the sequencer to idle and drops done; no command is in work.
`default_nettype none

module calendar_date_arithmetic #(
	parameter int MAX_YEAR = 9999
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         kind,
	input  wire logic [cda_pkg::DAY_W-1:0]    day_a,
	input  wire logic [cda_pkg::MON_W-1:0]    month_a,
	input  wire logic [cda_pkg::YEAR_W-1:0]   year_a,
	input  wire logic [cda_pkg::DAY_W-1:0]    day_b,
	input  wire logic [cda_pkg::MON_W-1:0]    month_b,
	input  wire logic [cda_pkg::YEAR_W-1:0]   year_b,
	input  wire logic [cda_pkg::CNT_W-1:0]    day_count,
	output logic                              done,
	output logic      [cda_pkg::CNT_W-1:0]    days_between,
	output logic      [cda_pkg::DAY_W-1:0]    result_day,
	output logic      [cda_pkg::MON_W-1:0]    result_month,
	output logic      [cda_pkg::YEAR_W-1:0]   result_year,
	output logic      [1:0]                   status
);

	localparam int TOP_YEAR = (MAX_YEAR > cda_pkg::YEAR_FIELD_MAX) ? cda_pkg::YEAR_FIELD_MAX :
		((MAX_YEAR < 1) ? 1 : MAX_YEAR);
	localparam int LAST_SERIAL = 365 * TOP_YEAR + TOP_YEAR / 4 - TOP_YEAR / 100
		+ TOP_YEAR / 400 - 1;
	localparam logic [cda_pkg::ACC_W-1:0] LAST = cda_pkg::ACC_W'(LAST_SERIAL);
	localparam logic [cda_pkg::YEAR_W-1:0] TOP = cda_pkg::YEAR_W'(TOP_YEAR);

	typedef enum logic [3:0] {
		ST_IDLE, ST_S400, ST_S100, ST_S4, ST_S1, ST_SMD, ST_DIFF, ST_ADD, ST_CHK,
		ST_D400, ST_D100, ST_D4, ST_D1, ST_DMON
	} state_t;

	state_t state_q;

	logic                         kind_q;
	logic                         second_q;
	logic [cda_pkg::CNT_W-1:0]    cnt_q;
	logic [cda_pkg::DAY_W-1:0]    day_q;
	logic [cda_pkg::MON_W-1:0]    mon_q;
	logic [cda_pkg::YEAR_W-1:0]   p_q;
	logic [cda_pkg::DAY_W-1:0]    db_q;
	logic [cda_pkg::MON_W-1:0]    mb_q;
	logic [cda_pkg::YEAR_W-1:0]   pb_q;
	logic [cda_pkg::ACC_W-1:0]    acc_q;
	logic [cda_pkg::ACC_W-1:0]    sa_q;
	logic [cda_pkg::YEAR_W-1:0]   yr_q;
	logic [1:0]                   b_q;
	logic [4:0]                   c_q;
	logic [1:0]                   e_q;

	logic                         done_q;
	logic [cda_pkg::CNT_W-1:0]    days_q;
	logic [cda_pkg::DAY_W-1:0]    rday_q;
	logic [cda_pkg::MON_W-1:0]    rmon_q;
	logic [cda_pkg::YEAR_W-1:0]   ryear_q;
	logic [1:0]                   status_q;

	logic [cda_pkg::DAY_W-1:0]    day_ac, day_bc;
	logic [cda_pkg::MON_W-1:0]    mon_ac, mon_bc;
	logic [cda_pkg::YEAR_W-1:0]   p_ac, p_bc;

	cda_pkg::alu_req_t            alu_req;
	cda_pkg::alu_rsp_t            alu_rsp;

	logic                         leap_w;
	logic [cda_pkg::DAY_W-1:0]    mlen_w;
	logic [cda_pkg::DAY_W-1:0]    dd_w;
	logic [cda_pkg::ACC_W-1:0]    md_op_w;

	cda_clamp #(.TOP_YEAR(TOP_YEAR)) u_clamp_a (
		.day(day_a), .month(month_a), .year(year_a),
		.day_c(day_ac), .month_c(mon_ac), .year_m1(p_ac)
	);

	cda_clamp #(.TOP_YEAR(TOP_YEAR)) u_clamp_b (
		.day(day_b), .month(month_b), .year(year_b),
		.day_c(day_bc), .month_c(mon_bc), .year_m1(p_bc)
	);

	cda_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	always_comb begin
		leap_w  = (e_q == 2'd3) && ((c_q != 5'd24) || (b_q == 2'd3));
		mlen_w  = cda_pkg::month_len(mon_q, leap_w);
		dd_w    = (day_q > mlen_w) ? mlen_w : day_q;
		md_op_w = cda_pkg::ACC_W'(cda_pkg::cum_days(mon_q))
			+ cda_pkg::ACC_W'(leap_w && (mon_q > cda_pkg::MON_W'(2)))
			+ cda_pkg::ACC_W'(dd_w) - cda_pkg::ACC_W'(1);

		alu_req.sub = 1'b0;
		alu_req.a   = acc_q;
		alu_req.b   = '0;
		unique case (state_q)
			ST_S400: alu_req.b = cda_pkg::DAYS_400Y;
			ST_S100: alu_req.b = cda_pkg::DAYS_100Y;
			ST_S4:   alu_req.b = cda_pkg::DAYS_4Y;
			ST_S1:   alu_req.b = cda_pkg::DAYS_1Y;
			ST_SMD:  alu_req.b = md_op_w;
			ST_DIFF: begin
				alu_req.sub = 1'b1;
				alu_req.a   = sa_q;
				alu_req.b   = acc_q;
			end
			ST_ADD: begin
				alu_req.a = sa_q;
				alu_req.b = cda_pkg::ACC_W'(cnt_q);
			end
			ST_CHK: begin
				alu_req.sub = 1'b1;
				alu_req.a   = LAST;
				alu_req.b   = acc_q;
			end
			ST_D400: begin
				alu_req.sub = 1'b1;
				alu_req.b   = cda_pkg::DAYS_400Y;
			end
			ST_D100: begin
				alu_req.sub = 1'b1;
				alu_req.b   = cda_pkg::DAYS_100Y;
			end
			ST_D4: begin
				alu_req.sub = 1'b1;
				alu_req.b   = cda_pkg::DAYS_4Y;
			end
			ST_D1: begin
				alu_req.sub = 1'b1;
				alu_req.b   = cda_pkg::DAYS_1Y;
			end
			ST_DMON: begin
				alu_req.sub = 1'b1;
				alu_req.b   = cda_pkg::ACC_W'(mlen_w);
			end
			ST_IDLE: alu_req.b = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			kind_q   <= 1'b0;
			second_q <= 1'b0;
			cnt_q    <= '0;
			day_q    <= '0;
			mon_q    <= '0;
			p_q      <= '0;
			db_q     <= '0;
			mb_q     <= '0;
			pb_q     <= '0;
			acc_q    <= '0;
			sa_q     <= '0;
			yr_q     <= '0;
			b_q      <= '0;
			c_q      <= '0;
			e_q      <= '0;
			days_q   <= '0;
			rday_q   <= '0;
			rmon_q   <= '0;
			ryear_q  <= '0;
			status_q <= cda_pkg::STAT_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						kind_q   <= kind;
						cnt_q    <= day_count;
						day_q    <= day_ac;
						mon_q    <= mon_ac;
						p_q      <= p_ac;
						db_q     <= day_bc;
						mb_q     <= mon_bc;
						pb_q     <= p_bc;
						acc_q    <= '0;
						b_q      <= '0;
						c_q      <= '0;
						e_q      <= '0;
						second_q <= 1'b0;
						state_q  <= ST_S400;
					end
				end
				ST_S400: begin
					if (p_q >= cda_pkg::YEAR_W'(400)) begin
						p_q   <= p_q - cda_pkg::YEAR_W'(400);
						acc_q <= alu_rsp.res;
					end else begin
						state_q <= ST_S100;
					end
				end
				ST_S100: begin
					if (p_q >= cda_pkg::YEAR_W'(100)) begin
						p_q   <= p_q - cda_pkg::YEAR_W'(100);
						acc_q <= alu_rsp.res;
						b_q   <= b_q + 2'd1;
					end else begin
						state_q <= ST_S4;
					end
				end
				ST_S4: begin
					if (p_q >= cda_pkg::YEAR_W'(4)) begin
						p_q   <= p_q - cda_pkg::YEAR_W'(4);
						acc_q <= alu_rsp.res;
						c_q   <= c_q + 5'd1;
					end else begin
						state_q <= ST_S1;
					end
				end
				ST_S1: begin
					if (p_q != '0) begin
						p_q   <= p_q - cda_pkg::YEAR_W'(1);
						acc_q <= alu_rsp.res;
						e_q   <= e_q + 2'd1;
					end else begin
						state_q <= ST_SMD;
					end
				end
				ST_SMD: begin
					if (second_q) begin
						acc_q   <= alu_rsp.res;
						state_q <= ST_DIFF;
					end else begin
						sa_q <= alu_rsp.res;
						if (kind_q == cda_pkg::KIND_ADD) begin
							state_q <= ST_ADD;
						end else begin
							second_q <= 1'b1;
							day_q    <= db_q;
							mon_q    <= mb_q;
							p_q      <= pb_q;
							acc_q    <= '0;
							b_q      <= '0;
							c_q      <= '0;
							e_q      <= '0;
							state_q  <= ST_S400;
						end
					end
				end
				ST_DIFF: begin
					rday_q  <= '0;
					rmon_q  <= '0;
					ryear_q <= '0;
					if (alu_rsp.borrow) begin
						days_q   <= '0;
						status_q <= cda_pkg::STAT_BEFORE;
					end else begin
						status_q <= cda_pkg::STAT_OK;
						if (alu_rsp.res[cda_pkg::ACC_W-1:cda_pkg::CNT_W] != '0) begin
							days_q <= cda_pkg::COUNT_MAX;
						end else begin
							days_q <= alu_rsp.res[cda_pkg::CNT_W-1:0];
						end
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_ADD: begin
					acc_q   <= alu_rsp.res;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (alu_rsp.borrow) begin
						days_q   <= '0;
						rday_q   <= cda_pkg::DAY_W'(31);
						rmon_q   <= cda_pkg::MON_W'(12);
						ryear_q  <= TOP;
						status_q <= cda_pkg::STAT_OVF;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						yr_q    <= cda_pkg::YEAR_W'(1);
						mon_q   <= cda_pkg::MON_W'(1);
						b_q     <= '0;
						c_q     <= '0;
						e_q     <= '0;
						state_q <= ST_D400;
					end
				end
				ST_D400: begin
					if (!alu_rsp.borrow) begin
						acc_q <= alu_rsp.res;
						yr_q  <= yr_q + cda_pkg::YEAR_W'(400);
					end else begin
						state_q <= ST_D100;
					end
				end
				ST_D100: begin
					if (!alu_rsp.borrow && (b_q != 2'd3)) begin
						acc_q <= alu_rsp.res;
						yr_q  <= yr_q + cda_pkg::YEAR_W'(100);
						b_q   <= b_q + 2'd1;
					end else begin
						state_q <= ST_D4;
					end
				end
				ST_D4: begin
					if (!alu_rsp.borrow) begin
						acc_q <= alu_rsp.res;
						yr_q  <= yr_q + cda_pkg::YEAR_W'(4);
						c_q   <= c_q + 5'd1;
					end else begin
						state_q <= ST_D1;
					end
				end
				ST_D1: begin
					if (!alu_rsp.borrow && (e_q != 2'd3)) begin
						acc_q <= alu_rsp.res;
						yr_q  <= yr_q + cda_pkg::YEAR_W'(1);
						e_q   <= e_q + 2'd1;
					end else begin
						state_q <= ST_DMON;
					end
				end
				ST_DMON: begin
					if (!alu_rsp.borrow && (mon_q != cda_pkg::MON_W'(12))) begin
						acc_q <= alu_rsp.res;
						mon_q <= mon_q + cda_pkg::MON_W'(1);
					end else begin
						days_q   <= '0;
						rday_q   <= acc_q[cda_pkg::DAY_W-1:0] + cda_pkg::DAY_W'(1);
						rmon_q   <= mon_q;
						ryear_q  <= yr_q;
						status_q <= cda_pkg::STAT_OK;
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign days_between = days_q;
	assign result_day   = rday_q;
	assign result_month = rmon_q;
	assign result_year  = ryear_q;
	assign status       = status_q;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none

module testbench;

	localparam int MAX_YEAR       = 9999;
	localparam int TOP_YEAR       = (MAX_YEAR > cda_pkg::YEAR_FIELD_MAX) ?
		cda_pkg::YEAR_FIELD_MAX : MAX_YEAR;
	localparam int RANDOM_ITEMS   = 525;
	localparam int MAX_GAP        = 15;
	localparam int DRAIN_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 1500;

	typedef struct packed {
		logic                       kind;
		logic [cda_pkg::DAY_W-1:0]  day_a;
		logic [cda_pkg::MON_W-1:0]  month_a;
		logic [cda_pkg::YEAR_W-1:0] year_a;
		logic [cda_pkg::DAY_W-1:0]  day_b;
		logic [cda_pkg::MON_W-1:0]  month_b;
		logic [cda_pkg::YEAR_W-1:0] year_b;
		logic [cda_pkg::CNT_W-1:0]  day_count;
	} date_cmd_t;

	typedef struct packed {
		logic [cda_pkg::CNT_W-1:0]  days_between;
		logic [cda_pkg::DAY_W-1:0]  day;
		logic [cda_pkg::MON_W-1:0]  month;
		logic [cda_pkg::YEAR_W-1:0] year;
		logic [1:0]                 status;
	} date_ans_t;

	typedef struct packed {
		date_cmd_t cmd;
		logic      typed;
		date_ans_t ans;
	} directed_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic                       kind;
	logic [cda_pkg::DAY_W-1:0]  day_a;
	logic [cda_pkg::MON_W-1:0]  month_a;
	logic [cda_pkg::YEAR_W-1:0] year_a;
	logic [cda_pkg::DAY_W-1:0]  day_b;
	logic [cda_pkg::MON_W-1:0]  month_b;
	logic [cda_pkg::YEAR_W-1:0] year_b;
	logic [cda_pkg::CNT_W-1:0]  day_count;
	logic                       done;
	logic [cda_pkg::CNT_W-1:0]  days_between;
	logic [cda_pkg::DAY_W-1:0]  result_day;
	logic [cda_pkg::MON_W-1:0]  result_month;
	logic [cda_pkg::YEAR_W-1:0] result_year;
	logic [1:0]                 status;

	date_ans_t   answers_due [$];
	date_ans_t   oldest_answer;
	int unsigned mismatches   = 0;
	int unsigned results_seen = 0;
	int unsigned idle_cycles  = 0;
	int unsigned burst_left   = 0;

	directed_row_t directed_rows [25] = '{
		'{'{cda_pkg::KIND_DIFF,  1,  1,     1,  1,  1,    1,          0}, 1'b1,
			'{      0,  0,  0,    0, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_DIFF, 31, 12,  9999,  1,  1,    1,          0}, 1'b1,
			'{3652058,  0,  0,    0, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_DIFF,  1,  1,     1, 31, 12, 9999,          0}, 1'b1,
			'{      0,  0,  0,    0, cda_pkg::STAT_BEFORE}},
		'{'{cda_pkg::KIND_ADD,   1,  1,     1,  0,  0,    0,          0}, 1'b1,
			'{      0,  1,  1,    1, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_ADD,  31, 12,  9999,  0,  0,    0,          0}, 1'b1,
			'{      0, 31, 12, 9999, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_ADD,  31, 12,  9999,  0,  0,    0,          1}, 1'b1,
			'{      0, 31, 12, 9999, cda_pkg::STAT_OVF}},
		'{'{cda_pkg::KIND_ADD,   1,  1,     1,  0,  0,    0, 22'h3FFFFF}, 1'b1,
			'{      0, 31, 12, 9999, cda_pkg::STAT_OVF}},
		'{'{cda_pkg::KIND_ADD,   1,  1,     1,  0,  0,    0,    3652058}, 1'b1,
			'{      0, 31, 12, 9999, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_ADD,  28,  2,  2000,  0,  0,    0,          1}, 1'b1,
			'{      0, 29,  2, 2000, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_ADD,  28,  2,  1900,  0,  0,    0,          1}, 1'b1,
			'{      0,  1,  3, 1900, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_ADD,  28,  2,  2024,  0,  0,    0,          1}, 1'b1,
			'{      0, 29,  2, 2024, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_ADD,  28,  2,  2023,  0,  0,    0,          1}, 1'b1,
			'{      0,  1,  3, 2023, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_ADD,  31, 12,  1999,  0,  0,    0,          1}, 1'b1,
			'{      0,  1,  1, 2000, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_DIFF,  1,  3,  2000, 28,  2, 2000,          0}, 1'b1,
			'{      2,  0,  0,    0, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_DIFF,  1,  3,  1900, 28,  2, 1900,          0}, 1'b1,
			'{      1,  0,  0,    0, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_DIFF,  0,  0,     0,  1,  1,    1,          0}, 1'b1,
			'{      0,  0,  0,    0, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_DIFF, 31, 15, 16383, 31, 12, 9999,          0}, 1'b1,
			'{      0,  0,  0,    0, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_ADD,  31,  2,  2023,  0,  0,    0,          0}, 1'b1,
			'{      0, 28,  2, 2023, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_ADD,  31,  4,  2021,  0,  0,    0,          0}, 1'b1,
			'{      0, 30,  4, 2021, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_ADD,  30,  2,  2024,  0,  0,    0,          0}, 1'b1,
			'{      0, 29,  2, 2024, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_DIFF,  1,  1,  2001,  1,  1, 2000,          0}, 1'b1,
			'{    366,  0,  0,    0, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_DIFF,  1,  1,  1901,  1,  1, 1900,          0}, 1'b1,
			'{    365,  0,  0,    0, cda_pkg::STAT_OK}},
		'{'{cda_pkg::KIND_DIFF, 17,  6,  1970,  4,  7, 1776, 22'h3FFFFF}, 1'b0, '0},
		'{'{cda_pkg::KIND_ADD,   9, 11,  1989, 31, 15, 16383,     12345}, 1'b0, '0},
		'{'{cda_pkg::KIND_ADD,   1,  1,     1,  0,  0,    0,     146097}, 1'b1,
			'{      0,  1,  1,  401, cda_pkg::STAT_OK}}
	};

	calendar_date_arithmetic #(
		.MAX_YEAR(MAX_YEAR)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.day_a       (day_a),
		.month_a     (month_a),
		.year_a      (year_a),
		.day_b       (day_b),
		.month_b     (month_b),
		.year_b      (year_b),
		.day_count   (day_count),
		.done        (done),
		.days_between(days_between),
		.result_day  (result_day),
		.result_month(result_month),
		.result_year (result_year),
		.status      (status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
		case (m)
			2: return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	// clamp the date into range, then count days from 1/1/0001
	function automatic int unsigned day_serial(input logic [cda_pkg::DAY_W-1:0] d,
			input logic [cda_pkg::MON_W-1:0] m, input logic [cda_pkg::YEAR_W-1:0] y);
		int unsigned dd, mm, yy, p, n, i;
		yy = y;
		mm = m;
		dd = d;
		if (yy < 1) yy = 1;
		if (yy > TOP_YEAR) yy = TOP_YEAR;
		if (mm < 1) mm = 1;
		if (mm > 12) mm = 12;
		if (dd < 1) dd = 1;
		if (dd > month_days(mm, yy)) dd = month_days(mm, yy);
		p = yy - 1;
		n = p * cda_pkg::DAYS_1Y + p / 4 - p / 100 + p / 400;
		for (i = 1; i < mm; i++) n += month_days(i, yy);
		return n + dd - 1;
	endfunction

	function automatic date_ans_t compute_date_op(input date_cmd_t c);
		date_ans_t   a;
		int unsigned sa, sb, diff, last, r, q400, q100, q4, q1, yr, mo;
		a = '0;
		sa = day_serial(c.day_a, c.month_a, c.year_a);
		if (c.kind == cda_pkg::KIND_DIFF) begin
			sb = day_serial(c.day_b, c.month_b, c.year_b);
			if (sa < sb) begin
				a.status = cda_pkg::STAT_BEFORE;
			end else begin
				diff = sa - sb;
				if (diff > cda_pkg::COUNT_MAX) diff = cda_pkg::COUNT_MAX;
				a.days_between = cda_pkg::CNT_W'(diff);
			end
		end else begin
			last = day_serial(5'd31, 4'd12, cda_pkg::YEAR_W'(TOP_YEAR));
			if (c.day_count > last - sa) begin
				a.day    = 5'd31;
				a.month  = 4'd12;
				a.year   = cda_pkg::YEAR_W'(TOP_YEAR);
				a.status = cda_pkg::STAT_OVF;
			end else begin
				r = sa + c.day_count;
				q400 = r / cda_pkg::DAYS_400Y;
				r = r % cda_pkg::DAYS_400Y;
				q100 = r / cda_pkg::DAYS_100Y;
				if (q100 > 3) q100 = 3;
				r -= q100 * cda_pkg::DAYS_100Y;
				q4 = r / cda_pkg::DAYS_4Y;
				r -= q4 * cda_pkg::DAYS_4Y;
				q1 = r / cda_pkg::DAYS_1Y;
				if (q1 > 3) q1 = 3;
				r -= q1 * cda_pkg::DAYS_1Y;
				yr = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
				mo = 1;
				while (mo < 12 && r >= month_days(mo, yr)) begin
					r -= month_days(mo, yr);
					mo++;
				end
				a.day   = cda_pkg::DAY_W'(r + 1);
				a.month = cda_pkg::MON_W'(mo);
				a.year  = cda_pkg::YEAR_W'(yr);
			end
		end
		return a;
	endfunction

	function automatic void pick_date(output logic [cda_pkg::DAY_W-1:0] d,
			output logic [cda_pkg::MON_W-1:0] m, output logic [cda_pkg::YEAR_W-1:0] y);
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			d = cda_pkg::DAY_W'($urandom);
			m = cda_pkg::MON_W'($urandom);
			y = cda_pkg::YEAR_W'($urandom);
		end else begin
			if (sel < 30) y = cda_pkg::YEAR_W'($urandom_range(1, 400));
			else if (sel < 45) y = cda_pkg::YEAR_W'($urandom_range(TOP_YEAR - 100, TOP_YEAR));
			else y = cda_pkg::YEAR_W'($urandom_range(1, TOP_YEAR));
			m = cda_pkg::MON_W'($urandom_range(1, 12));
			if (sel < 52) d = cda_pkg::DAY_W'($urandom_range(1, 31));
			else d = cda_pkg::DAY_W'($urandom_range(1, month_days(m, y)));
		end
	endfunction

	function automatic date_cmd_t random_date_cmd();
		date_cmd_t   c;
		int unsigned sel;
		c.kind = ($urandom_range(0, 1) == 0) ? cda_pkg::KIND_DIFF : cda_pkg::KIND_ADD;
		pick_date(c.day_a, c.month_a, c.year_a);
		pick_date(c.day_b, c.month_b, c.year_b);
		sel = $urandom_range(0, 99);
		if (sel < 35) c.day_count = cda_pkg::CNT_W'($urandom_range(0, 400));
		else if (sel < 60) c.day_count = cda_pkg::CNT_W'($urandom_range(0, 40000));
		else if (sel < 85) c.day_count = cda_pkg::CNT_W'($urandom_range(0, 3652058));
		else c.day_count = cda_pkg::CNT_W'($urandom);
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic issue_date_cmd(input date_cmd_t c, input logic typed, input date_ans_t ans);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
			if (gap > 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		@(negedge clk);
		kind      <= c.kind;
		day_a     <= c.day_a;
		month_a   <= c.month_a;
		year_a    <= c.year_a;
		day_b     <= c.day_b;
		month_b   <= c.month_b;
		year_b    <= c.year_b;
		day_count <= c.day_count;
		start     <= 1'b1;
		do @(posedge clk); while (busy);
		answers_due.push_back(typed ? ans : compute_date_op(c));
		burst_left--;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				report_mismatch("result with no transaction pending");
			end else begin
				oldest_answer = answers_due.pop_front();
				check_field("days_between", days_between, oldest_answer.days_between);
				check_field("result_day", result_day, oldest_answer.day);
				check_field("result_month", result_month, oldest_answer.month);
				check_field("result_year", result_year, oldest_answer.year);
				check_field("status", status, oldest_answer.status);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("testbench failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		kind      = 1'b0;
		day_a     = '0;
		month_a   = '0;
		year_a    = '0;
		day_b     = '0;
		month_b   = '0;
		year_b    = '0;
		day_count = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed_rows[i])
			issue_date_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].ans);
		repeat (RANDOM_ITEMS) issue_date_cmd(random_date_cmd(), 1'b0, '0);
		@(negedge clk);
		start <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
